// File: hw/rtl/cmti_pkg.sv
// Shared types, codes and constants of the colour matrix interpolation core.
package cmti_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int COEF_COUNT      = 12;
   localparam int QUOT_BITS       = 16;

   localparam logic [1:0] OP_WR_TEMP = 2'd0;
   localparam logic [1:0] OP_WR_COEF = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK,
      ST_FIRST,
      ST_LASTCHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SPAN,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_IP_RD0,
      ST_IP_RD1,
      ST_IP_MUL,
      ST_IP_DIVI,
      ST_IP_DIV,
      ST_IP_RND,
      ST_IP_OUT
   } cmti_state_type;

   typedef enum logic [1:0] {
      TSEL_FIRST,
      TSEL_LAST,
      TSEL_IDX
   } cmti_tsel_type;

   typedef enum logic {
      ESEL_FIRST,
      ESEL_LAST
   } cmti_esel_type;

   typedef struct packed {
      logic          take;
      logic          cap_query;
      logic          rd_temp;
      cmti_tsel_type tsel;
      logic          lat_k0;
      logic          idx_set1;
      logic          idx_inc;
      logic          hit;
      logic          set_e;
      cmti_esel_type esel;
      logic          slot_clr;
      logic          slot_inc;
      logic          rd_coef;
      logic          coef_hi;
      logic          lat_m0;
      logic          lat_span;
      logic          mul_go;
      logic          div_init;
      logic          div_step;
      logic          rnd;
      logic          out_direct;
      logic          out_interp;
   } cmti_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic t_le;
      logic t_ge;
      logic span_le0;
      logic div_last;
      logic slot_last;
      logic out_free;
   } cmti_status_type;

endpackage

// File: hw/rtl/colour_matrix_temperature_interp_core.sv
// Top level of the colour matrix interpolation core: register port, sequencer and datapath.
//
//   channel  | direction | signals                     | payload
//   req      | in        | req_tvalid/tready/tdata/tuser | tuser op; tdata entry, slot, value, kelvin
//   rsp      | out       | rsp_tvalid/tready/tdata/tlast | tdata slot, coefficient; tlast on slot 11
//   csr      | in        | csr_psel/penable/pwrite/...   | entry_count at byte address 0
//
// A query first scans the temperature table entry by entry (single read port of the
// temperature RAM). An end or zero-span query then emits 12 coefficients; an interpolated
// query computes each coefficient with the 16-step serial divider. Reset clears control
// only: the tables hold no data until written and take no clearing pass. A stalled result
// holds the sequencer; a new request is taken while the final result still waits.
module colour_matrix_temperature_interp_core
   import cmti_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry[3:0], coef_slot[7:4], coef_value[23:8], temperature[39:24]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_slot[3:0], out_coef[19:4], zero[23:20]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [4:0] entry_count_ff;
   logic       reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = csr_paddr[2] == REG_ENTRY_COUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 5'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         entry_count_ff <= csr_pwdata[4:0];
      end
   end

   assign csr_prdata = reg_hit ? {27'd0, entry_count_ff} : 32'd0;

   cmti_cmd_type    cmd;
   cmti_status_type status;
   logic [3:0]      out_slot;
   logic [15:0]     out_coef;

   cmti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_op    (req_tuser),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   cmti_dpath #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .entry_count    (entry_count_ff),
      .req_op         (req_tuser),
      .req_entry      (req_tdata[3:0]),
      .req_coef_slot  (req_tdata[7:4]),
      .req_coef_value (req_tdata[23:8]),
      .req_temperature(req_tdata[39:24]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_out_slot   (out_slot),
      .rsp_out_coef   (out_coef),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_coef, out_slot};

endmodule

// File: hw/rtl/cmti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmti_ram
   import cmti_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cmti_ctrl.sv
// Query sequencer: table search, entry emission and per-coefficient interpolation steps.
module cmti_ctrl
   import cmti_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic [1:0]      req_op,
   output logic            req_tready,
   input  cmti_status_type status,
   output cmti_cmd_type    cmd
);

   cmti_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.tsel   = TSEL_FIRST;
      cmd.esel   = ESEL_FIRST;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_op == OP_QUERY) begin
                  cmd.cap_query = 1'b1;
                  state_in      = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            if (status.n_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_temp = 1'b1;
               cmd.tsel    = TSEL_FIRST;
               state_in    = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.lat_k0 = 1'b1;
            if (status.n_one || status.t_le) begin
               cmd.set_e    = 1'b1;
               cmd.esel     = ESEL_FIRST;
               cmd.slot_clr = 1'b1;
               state_in     = ST_EMIT_RD;
            end else begin
               cmd.rd_temp = 1'b1;
               cmd.tsel    = TSEL_LAST;
               state_in    = ST_LASTCHK;
            end
         end
         ST_LASTCHK: begin
            if (status.t_ge) begin
               cmd.set_e    = 1'b1;
               cmd.esel     = ESEL_LAST;
               cmd.slot_clr = 1'b1;
               state_in     = ST_EMIT_RD;
            end else begin
               cmd.idx_set1 = 1'b1;
               state_in     = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            cmd.rd_temp = 1'b1;
            cmd.tsel    = TSEL_IDX;
            state_in    = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            if (status.t_le) begin
               cmd.hit  = 1'b1;
               state_in = ST_SPAN;
            end else begin
               // slide the window up by one entry
               cmd.lat_k0  = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SPAN: begin
            cmd.slot_clr = 1'b1;
            cmd.lat_span = 1'b1;
            if (status.span_le0) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IP_RD0;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_coef = 1'b1;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.out_direct = 1'b1;
               if (status.slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_inc = 1'b1;
                  state_in     = ST_EMIT_RD;
               end
            end
         end
         ST_IP_RD0: begin
            cmd.rd_coef = 1'b1;
            state_in    = ST_IP_RD1;
         end
         ST_IP_RD1: begin
            cmd.lat_m0  = 1'b1;
            cmd.rd_coef = 1'b1;
            cmd.coef_hi = 1'b1;
            state_in    = ST_IP_MUL;
         end
         ST_IP_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_IP_DIVI;
         end
         ST_IP_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = ST_IP_DIV;
         end
         ST_IP_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IP_RND;
            end
         end
         ST_IP_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_IP_OUT;
         end
         ST_IP_OUT: begin
            if (status.out_free) begin
               cmd.out_interp = 1'b1;
               if (status.slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_inc = 1'b1;
                  state_in     = ST_IP_RD0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/cmti_dpath.sv
// Datapath: tables, search registers, multiplier, serial divider, rounding and result register.
module cmti_dpath
   import cmti_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cmti_cmd_type    cmd,
   output cmti_status_type status,
   input  logic [4:0]      entry_count,
   input  logic [1:0]      req_op,
   input  logic [3:0]      req_entry,
   input  logic [3:0]      req_coef_slot,
   input  logic [15:0]     req_coef_value,
   input  logic [15:0]     req_temperature,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [3:0]      rsp_out_slot,
   output logic [15:0]     rsp_out_coef,
   output logic            rsp_last
);

   localparam int EW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COEF_DEPTH = MAX_ENTRIES * COEF_COUNT;
   localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int CNT_W      = $clog2(QUOT_BITS);
   localparam logic [8:0]       MAX9      = 9'(MAX_ENTRIES);
   localparam logic [3:0]       SLOT_LAST = 4'(COEF_COUNT - 1);
   localparam logic [3:0]       SLOT_END  = 4'(COEF_COUNT);
   localparam logic [12:0]      COEF13    = 13'(COEF_COUNT);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(QUOT_BITS - 1);

   // request decode and table writes
   logic [8:0]     entry9;
   logic           entry_ok;
   logic           temp_we;
   logic           coef_we;
   logic [12:0]    coef_waddr13;
   logic [EW-1:0]  temp_waddr;

   assign entry9       = {5'b0, req_entry};
   assign entry_ok     = entry9 < MAX9;
   assign temp_we      = cmd.take && (req_op == OP_WR_TEMP) && entry_ok;
   assign coef_we      = cmd.take && (req_op == OP_WR_COEF) && entry_ok &&
                         (req_coef_slot < SLOT_END);
   assign temp_waddr   = entry9[EW-1:0];
   assign coef_waddr13 = 13'(req_entry) * COEF13 + 13'(req_coef_slot);

   // query registers
   logic [15:0]   t_ff, k0_ff, k1_ff, span_ff, dt_ff;
   logic [4:0]    n_ff;
   logic [EW-1:0] j_ff, e_ff;
   logic [3:0]    slot_ff;
   logic [8:0]    ec9, n9, nm1_9;

   assign ec9   = {4'b0, entry_count};
   assign n9    = (ec9 > MAX9) ? MAX9 : ec9;
   assign nm1_9 = {4'b0, n_ff} - 9'd1;

   // table read ports
   logic [EW-1:0]  temp_raddr;
   logic [15:0]    temp_rd;
   logic [12:0]    base13;
   logic [12:0]    coef_raddr13;
   logic [15:0]    coef_rd;

   always_comb begin
      case (cmd.tsel)
         TSEL_FIRST: temp_raddr = '0;
         TSEL_LAST:  temp_raddr = nm1_9[EW-1:0];
         TSEL_IDX:   temp_raddr = j_ff;
         default:    temp_raddr = '0;
      endcase
   end

   assign base13       = cmd.coef_hi ? (13'(e_ff) + 13'd1) : 13'(e_ff);
   assign coef_raddr13 = base13 * COEF13 + 13'(slot_ff);

   cmti_ram #(
      .WIDTH(16),
      .DEPTH(MAX_ENTRIES)
   ) u_temp_ram (
      .clock  (clock),
      .wr_en  (temp_we),
      .wr_addr(temp_waddr),
      .wr_data(req_temperature),
      .rd_en  (cmd.rd_temp),
      .rd_addr(temp_raddr),
      .rd_data(temp_rd)
   );

   cmti_ram #(
      .WIDTH(16),
      .DEPTH(COEF_DEPTH)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (coef_we),
      .wr_addr(coef_waddr13[CAW-1:0]),
      .wr_data(req_coef_value),
      .rd_en  (cmd.rd_coef),
      .rd_addr(coef_raddr13[CAW-1:0]),
      .rd_data(coef_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap_query) begin
         t_ff <= req_temperature;
         n_ff <= n9[4:0];
      end
      if (cmd.lat_k0) begin
         k0_ff <= temp_rd;
      end
      if (cmd.idx_set1) begin
         j_ff <= EW'(1);
      end else if (cmd.idx_inc) begin
         j_ff <= j_ff + EW'(1);
      end
      if (cmd.hit) begin
         k1_ff <= temp_rd;
         e_ff  <= j_ff - EW'(1);
      end else if (cmd.set_e) begin
         e_ff <= (cmd.esel == ESEL_LAST) ? nm1_9[EW-1:0] : '0;
      end
      if (cmd.lat_span) begin
         span_ff <= k1_ff - k0_ff;
         dt_ff   <= t_ff - k0_ff;
      end
      if (cmd.slot_clr) begin
         slot_ff <= '0;
      end else if (cmd.slot_inc) begin
         slot_ff <= slot_ff + 4'd1;
      end
   end

   // interpolation: product, serial divide, round to nearest even
   logic signed [15:0] m0_ff;
   logic signed [33:0] prod_ff, prod_in;
   logic signed [16:0] diff, dt_s;
   logic [33:0]        prod_neg;
   logic [31:0]        mag;
   logic [15:0]        rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   logic [16:0]        shifted, trial;
   logic               fits;
   logic [15:0]        res_ff;

   assign diff     = $signed({coef_rd[15], coef_rd}) - $signed({m0_ff[15], m0_ff});
   assign dt_s     = $signed({1'b0, dt_ff});
   assign prod_in  = dt_s * diff;
   assign prod_neg = 34'd0 - prod_ff;
   assign mag      = prod_ff[33] ? prod_neg[31:0] : prod_ff[31:0];

   assign shifted = {rem_ff, dvd_ff[15]};
   assign trial   = shifted - {1'b0, span_ff};
   assign fits    = shifted >= {1'b0, span_ff};
   assign rem_in  = fits ? trial[15:0] : shifted[15:0];
   assign dvd_in  = {dvd_ff[14:0], fits};

   logic signed [17:0] q_s, floor_q, sum;
   logic [15:0]        rem_f, rem_neg;
   logic [16:0]        rem2;
   logic               round_up;

   always_comb begin
      q_s     = $signed({2'b00, dvd_ff});
      rem_neg = span_ff - rem_ff;
      if (!neg_ff) begin
         floor_q = q_s;
         rem_f   = rem_ff;
      end else if (rem_ff == 16'd0) begin
         floor_q = -q_s;
         rem_f   = 16'd0;
      end else begin
         floor_q = -q_s - 18'sd1;
         rem_f   = rem_neg;
      end
      rem2     = {rem_f, 1'b0};
      round_up = (rem2 > {1'b0, span_ff}) ||
                 ((rem2 == {1'b0, span_ff}) && floor_q[0]);
      sum      = $signed({{2{m0_ff[15]}}, m0_ff}) + floor_q +
                 (round_up ? 18'sd1 : 18'sd0);
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_m0) begin
         m0_ff <= $signed(coef_rd);
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_init) begin
         neg_ff <= prod_ff[33];
         rem_ff <= mag[31:16];
         dvd_ff <= mag[15:0];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.rnd) begin
         res_ff <= sum[15:0];
      end
   end

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  out_slot_ff;
   logic [15:0] out_coef_ff;
   logic        out_last_ff;
   logic        out_load;

   assign out_load     = cmd.out_direct || cmd.out_interp;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_slot_ff <= slot_ff;
         out_coef_ff <= cmd.out_interp ? res_ff : coef_rd;
         out_last_ff <= slot_ff == SLOT_LAST;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_out_slot = out_slot_ff;
   assign rsp_out_coef = out_coef_ff;
   assign rsp_last     = out_last_ff;

   assign status.n_zero    = n_ff == 5'd0;
   assign status.n_one     = n_ff == 5'd1;
   assign status.t_le      = t_ff <= temp_rd;
   assign status.t_ge      = t_ff >= temp_rd;
   assign status.span_le0  = k1_ff <= k0_ff;
   assign status.div_last  = cnt_ff == CNT_LAST;
   assign status.slot_last = slot_ff == SLOT_LAST;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

// File: hw/rtl/cmti_checker.sv
// Port-level checks of the colour matrix interpolation core, bound to the top level.
module cmti_checker
   import cmti_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   localparam logic [3:0] SLOT_LAST = 4'(COEF_COUNT - 1);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_last_on_final_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == SLOT_LAST)
      else $error("tlast on wrong slot");

   // a new request is only taken once the run has reached its final result
   a_ready_between_runs: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("request taken in the middle of a run");

endmodule

bind colour_matrix_temperature_interp_core cmti_checker u_cmti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
